// ===== src/ptc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pressure and temperature compensation package
// Field types and calibration register indexes shared by the interfaces and
// the compensation datapath.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int RAW_W   = 24;
    localparam int CAL_W   = 16;
    localparam int TEMP_W  = 19;
    localparam int PRESS_W = 32;
    localparam int IDX_W   = 3;

    typedef logic [RAW_W-1:0]          t_raw;
    typedef logic [CAL_W-1:0]          t_cal;
    typedef logic [IDX_W-1:0]          t_idx;
    typedef logic signed [TEMP_W-1:0]  t_temp;
    typedef logic signed [PRESS_W-1:0] t_press;

    localparam t_idx IDX_SENS      = 3'd0;
    localparam t_idx IDX_OFFSET    = 3'd1;
    localparam t_idx IDX_SENS_TC   = 3'd2;
    localparam t_idx IDX_OFFSET_TC = 3'd3;
    localparam t_idx IDX_REF_TEMP  = 3'd4;
    localparam t_idx IDX_TEMP_TC   = 3'd5;

endpackage
`default_nettype wire

// ===== src/ptc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pressure and temperature compensation channels
// Valid/ready channels for calibration writes, raw samples and results.
// ----------------------------------------------------------------------------
interface ptc_cfg_if;
    import ptc_pkg::*;

    logic valid;
    logic ready;
    t_idx index;
    t_cal data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

interface ptc_in_if;
    import ptc_pkg::*;

    logic valid;
    logic ready;
    t_raw raw_temp;
    t_raw raw_press;

    modport source (output valid, output raw_temp, output raw_press, input ready);
    modport sink (input valid, input raw_temp, input raw_press, output ready);
endinterface

interface ptc_out_if;
    import ptc_pkg::*;

    logic   valid;
    logic   ready;
    t_temp  temp_centi;
    t_press press_centi;
    logic   clamped;

    modport source (output valid, output temp_centi, output press_centi, output clamped,
                    input ready);
    modport sink (input valid, input temp_centi, input press_centi, input clamped,
                  output ready);
endinterface
`default_nettype wire

// ===== src/pressure_temp_compensation.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pressure and temperature compensation
// Second-order compensation of raw barometric sensor conversions.
// ----------------------------------------------------------------------------
// The block accepts one raw temperature and pressure pair per cycle unless
// the full pipeline is stalled, and returns the compensated temperature in
// 0.01 degC and pressure in 0.01 mbar, with a flag when either value was
// saturated. The datapath has ten register stages; each stage stalls only
// when it holds data that the next stage cannot take, so bubbles collapse and
// a stalled result does not block new samples until the pipeline is full.
// Calibration writes are taken in every cycle and must only be issued while
// no sample is in flight.
module pressure_temp_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptc_cfg_if.sink     i_cfg,
    ptc_in_if.sink      i_in,
    ptc_out_if.source   o_out
);
    import ptc_pkg::*;

    localparam int STAGES = 10;

    localparam logic signed [19:0] TEMP_REF  = 20'sd2000;
    localparam logic signed [19:0] TEMP_VLOW = -20'sd1500;
    localparam logic signed [19:0] TEMP_MAX  = 20'sd262143;
    localparam logic signed [19:0] TEMP_MIN  = -20'sd262144;
    localparam logic signed [51:0] PRESS_MAX = 52'sd2147483647;
    localparam logic signed [51:0] PRESS_MIN = -52'sd2147483648;

    t_cal r_cal_sens;
    t_cal r_cal_offset;
    t_cal r_cal_sens_tc;
    t_cal r_cal_offset_tc;
    t_cal r_cal_ref_temp;
    t_cal r_cal_temp_tc;

    logic [STAGES:1] r_vld;
    logic [STAGES:1] w_en;

    // Stage 1
    logic signed [24:0] n1_dt, r1_dt;
    t_raw               r1_d1;
    // Stage 2
    logic signed [41:0] n2_p_temp, r2_p_temp;
    logic signed [41:0] n2_p_off, r2_p_off;
    logic signed [41:0] n2_p_sens, r2_p_sens;
    logic signed [49:0] n2_dt2, r2_dt2;
    t_raw               r2_d1;
    // Stage 3
    logic signed [41:0] w3_temp_shift;
    logic [51:0]        w3_dt2_x3;
    logic [51:0]        w3_dt2_x5;
    logic signed [19:0] n3_temp1, r3_temp1;
    logic signed [47:0] n3_off, r3_off;
    logic signed [47:0] n3_sens, r3_sens;
    logic signed [19:0] n3_t2_low, r3_t2_low;
    logic signed [19:0] n3_t2_norm, r3_t2_norm;
    t_raw               r3_d1;
    // Stage 4
    logic               w4_low;
    logic               w4_vlow;
    logic signed [19:0] w4_d;
    logic signed [19:0] w4_e;
    logic signed [39:0] n4_dd, r4_dd;
    logic signed [39:0] n4_ee, r4_ee;
    logic signed [19:0] n4_temp2, r4_temp2;
    logic               r4_low;
    logic               r4_vlow;
    logic signed [47:0] r4_off;
    logic signed [47:0] r4_sens;
    t_raw               r4_d1;
    // Stage 5
    logic signed [47:0] w5_a;
    logic signed [47:0] w5_b;
    logic signed [47:0] n5_off2a, r5_off2a;
    logic signed [47:0] n5_off2b, r5_off2b;
    logic signed [47:0] n5_sens2a, r5_sens2a;
    logic signed [47:0] n5_sens2b, r5_sens2b;
    t_temp              n5_temp, r5_temp;
    logic               n5_tclamp, r5_tclamp;
    logic signed [47:0] r5_off;
    logic signed [47:0] r5_sens;
    t_raw               r5_d1;
    // Stage 6
    logic signed [47:0] n6_off, r6_off;
    logic signed [47:0] n6_sens, r6_sens;
    t_temp              r6_temp;
    logic               r6_tclamp;
    t_raw               r6_d1;
    // Stage 7
    logic [47:0]        n7_pl, r7_pl;
    logic signed [48:0] n7_ph, r7_ph;
    logic signed [47:0] r7_off;
    t_temp              r7_temp;
    logic               r7_tclamp;
    // Stage 8
    logic signed [72:0] n8_prod, r8_prod;
    logic signed [47:0] r8_off;
    t_temp              r8_temp;
    logic               r8_tclamp;
    // Stage 9
    logic signed [72:0] w9_shift;
    logic signed [51:0] n9_diff, r9_diff;
    t_temp              r9_temp;
    logic               r9_tclamp;
    // Stage 10
    logic signed [51:0] w10_press;
    t_press             n10_press, r10_press;
    logic               n10_clamped, r10_clamped;
    t_temp              r10_temp;

    // Calibration registers.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_sens      <= '0;
            r_cal_offset    <= '0;
            r_cal_sens_tc   <= '0;
            r_cal_offset_tc <= '0;
            r_cal_ref_temp  <= '0;
            r_cal_temp_tc   <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                IDX_SENS:      r_cal_sens      <= i_cfg.data;
                IDX_OFFSET:    r_cal_offset    <= i_cfg.data;
                IDX_SENS_TC:   r_cal_sens_tc   <= i_cfg.data;
                IDX_OFFSET_TC: r_cal_offset_tc <= i_cfg.data;
                IDX_REF_TEMP:  r_cal_ref_temp  <= i_cfg.data;
                IDX_TEMP_TC:   r_cal_temp_tc   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // A stage loads when it is empty or when its content moves on.
    always_comb begin
        w_en[STAGES] = !r_vld[STAGES] || o_out.ready;
        for (int k = STAGES - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign i_in.ready = w_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= i_in.valid;
            end
            for (int k = 2; k <= STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Datapath next values.
    always_comb begin
        n1_dt = $signed({1'b0, i_in.raw_temp}) - $signed({1'b0, r_cal_ref_temp, 8'd0});

        n2_p_temp = r1_dt * $signed({1'b0, r_cal_temp_tc});
        n2_p_off  = r1_dt * $signed({1'b0, r_cal_offset_tc});
        n2_p_sens = r1_dt * $signed({1'b0, r_cal_sens_tc});
        n2_dt2    = r1_dt * r1_dt;

        w3_temp_shift = r2_p_temp >>> 23;
        n3_temp1      = $signed(w3_temp_shift[19:0]) + TEMP_REF;
        n3_off        = $signed({15'd0, r_cal_offset, 17'd0})
                      + ($signed({{6{r2_p_off[41]}}, r2_p_off}) >>> 6);
        n3_sens       = $signed({16'd0, r_cal_sens, 16'd0})
                      + ($signed({{6{r2_p_sens[41]}}, r2_p_sens}) >>> 7);
        w3_dt2_x3     = {2'd0, r2_dt2} + {1'd0, r2_dt2, 1'b0};
        w3_dt2_x5     = {2'd0, r2_dt2} + {r2_dt2, 2'b0};
        n3_t2_low     = $signed({1'b0, w3_dt2_x3[51:33]});
        n3_t2_norm    = $signed({6'd0, w3_dt2_x5[51:38]});

        w4_low   = r3_temp1 < TEMP_REF;
        w4_vlow  = r3_temp1 < TEMP_VLOW;
        w4_d     = r3_temp1 - TEMP_REF;
        w4_e     = r3_temp1 - TEMP_VLOW;
        n4_dd    = w4_d * w4_d;
        n4_ee    = w4_e * w4_e;
        n4_temp2 = r3_temp1 - (w4_low ? r3_t2_low : r3_t2_norm);

        w5_a      = $signed({12'd0, r4_dd[39:4]});
        w5_b      = $signed({8'd0, r4_ee});
        n5_off2a  = r4_low ? w5_a * 48'sd61 : '0;
        n5_sens2a = r4_low ? w5_a * 48'sd29 : '0;
        n5_off2b  = r4_vlow ? w5_b * 48'sd17 : '0;
        n5_sens2b = r4_vlow ? w5_b * 48'sd9 : '0;
        if (r4_temp2 > TEMP_MAX) begin
            n5_temp   = TEMP_MAX[18:0];
            n5_tclamp = 1'b1;
        end else if (r4_temp2 < TEMP_MIN) begin
            n5_temp   = TEMP_MIN[18:0];
            n5_tclamp = 1'b1;
        end else begin
            n5_temp   = r4_temp2[18:0];
            n5_tclamp = 1'b0;
        end

        n6_off  = r5_off - r5_off2a - r5_off2b;
        n6_sens = r5_sens - r5_sens2a - r5_sens2b;

        n7_pl = r6_d1 * r6_sens[23:0];
        n7_ph = $signed({1'b0, r6_d1}) * $signed(r6_sens[47:24]);

        n8_prod = $signed({r7_ph, 24'd0}) + $signed({25'd0, r7_pl});

        w9_shift = r8_prod >>> 21;
        n9_diff  = $signed(w9_shift[51:0]) - $signed({{4{r8_off[47]}}, r8_off});

        w10_press = r9_diff >>> 15;
        if (w10_press > PRESS_MAX) begin
            n10_press   = PRESS_MAX[31:0];
            n10_clamped = 1'b1;
        end else if (w10_press < PRESS_MIN) begin
            n10_press   = PRESS_MIN[31:0];
            n10_clamped = 1'b1;
        end else begin
            n10_press   = w10_press[31:0];
            n10_clamped = r9_tclamp;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_dt <= n1_dt;
            r1_d1 <= i_in.raw_press;
        end
        if (w_en[2]) begin
            r2_p_temp <= n2_p_temp;
            r2_p_off  <= n2_p_off;
            r2_p_sens <= n2_p_sens;
            r2_dt2    <= n2_dt2;
            r2_d1     <= r1_d1;
        end
        if (w_en[3]) begin
            r3_temp1   <= n3_temp1;
            r3_off     <= n3_off;
            r3_sens    <= n3_sens;
            r3_t2_low  <= n3_t2_low;
            r3_t2_norm <= n3_t2_norm;
            r3_d1      <= r2_d1;
        end
        if (w_en[4]) begin
            r4_dd    <= n4_dd;
            r4_ee    <= n4_ee;
            r4_temp2 <= n4_temp2;
            r4_low   <= w4_low;
            r4_vlow  <= w4_vlow;
            r4_off   <= r3_off;
            r4_sens  <= r3_sens;
            r4_d1    <= r3_d1;
        end
        if (w_en[5]) begin
            r5_off2a  <= n5_off2a;
            r5_off2b  <= n5_off2b;
            r5_sens2a <= n5_sens2a;
            r5_sens2b <= n5_sens2b;
            r5_temp   <= n5_temp;
            r5_tclamp <= n5_tclamp;
            r5_off    <= r4_off;
            r5_sens   <= r4_sens;
            r5_d1     <= r4_d1;
        end
        if (w_en[6]) begin
            r6_off    <= n6_off;
            r6_sens   <= n6_sens;
            r6_temp   <= r5_temp;
            r6_tclamp <= r5_tclamp;
            r6_d1     <= r5_d1;
        end
        if (w_en[7]) begin
            r7_pl     <= n7_pl;
            r7_ph     <= n7_ph;
            r7_off    <= r6_off;
            r7_temp   <= r6_temp;
            r7_tclamp <= r6_tclamp;
        end
        if (w_en[8]) begin
            r8_prod   <= n8_prod;
            r8_off    <= r7_off;
            r8_temp   <= r7_temp;
            r8_tclamp <= r7_tclamp;
        end
        if (w_en[9]) begin
            r9_diff   <= n9_diff;
            r9_temp   <= r8_temp;
            r9_tclamp <= r8_tclamp;
        end
        if (w_en[10]) begin
            r10_press   <= n10_press;
            r10_clamped <= n10_clamped;
            r10_temp    <= r9_temp;
        end
    end

    assign o_out.valid       = r_vld[STAGES];
    assign o_out.temp_centi  = r10_temp;
    assign o_out.press_centi = r10_press;
    assign o_out.clamped     = r10_clamped;

endmodule
`default_nettype wire
